// ===== sv/button_debounce_repeat_multipress_core_assert.svh =====
// Assertion macros for the button debounce / repeat / multipress core.
// Used by button_debounce_repeat_multipress_core.sv; no other dependencies.
`ifndef BUTTON_DEBOUNCE_REPEAT_MULTIPRESS_CORE_ASSERT_SVH
`define BUTTON_DEBOUNCE_REPEAT_MULTIPRESS_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// implication checked at every clock edge out of reset
`define BDRM_ASSERT(label, clock, resetn, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) prop) else $error(msg);
// same, but the check also runs while reset is asserted
`define BDRM_ASSERT_ALWAYS(label, clock, prop, msg) \
    label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define BDRM_ASSERT(label, clock, resetn, prop, msg)
`define BDRM_ASSERT_ALWAYS(label, clock, prop, msg)
`endif

`endif

// ===== sv/bdrm_pkg.sv =====
// Shared constants and the tick-elapsed helper for the button core.
// No dependencies.
`default_nettype none

package bdrm_pkg;

    localparam int TIME_W   = 32;  // tick time width, modulo arithmetic
    localparam int DELAY_W  = 16;  // delay register width
    localparam int COUNT_W  = 8;   // multipress count width
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_DELAY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LOW     = 2'd3;

    localparam logic [DELAY_W-1:0] PRESS_DELAY_RST  = 16'd500;
    localparam logic [DELAY_W-1:0] REPEAT_DELAY_RST = 16'd100;
    localparam logic [DELAY_W-1:0] DEBOUNCE_RST     = 16'd25;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // (now - start) mod 2^TIME_W strictly greater than limit
    function automatic logic elapsed(
        input logic [TIME_W-1:0]  now_t,
        input logic [TIME_W-1:0]  start_t,
        input logic [DELAY_W-1:0] limit
    );
        logic [TIME_W-1:0] diff;
        diff = now_t - start_t;
        return diff > {{(TIME_W-DELAY_W){1'b0}}, limit};
    endfunction

endpackage

`default_nettype wire

// ===== sv/button_debounce_repeat_multipress_core.sv =====
// Push-button qualifier: debounce, auto-repeat key press and multipress count.
// Depends on bdrm_pkg and button_debounce_repeat_multipress_core_assert.svh.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+----------------------------------
//  in      | in  | in_valid / in_stall  | level, now
//  out     | out | out_valid / out_stall| key_event, burst_report
//  cfg     | in  | cfg_we               | cfg_index, cfg_data
//
// One request per clock while in_stall is low. All state updates for a request are
// computed in one pass of compare/update logic and land in the state and result
// registers at the accepting edge; the result registers form the output register.
// in_stall is high only while the output register is full and the consumer
// stalls, so the next request is taken while the downstream side drains.
// Reset (rst_n, async, low) restores the delay defaults, idle level high,
// both machines idle and an empty output register.
`default_nettype none

`include "button_debounce_repeat_multipress_core_assert.svh"

module button_debounce_repeat_multipress_core
    import bdrm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // request channel
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 level,
    input  wire logic [TIME_W-1:0]    now,
    // result channel
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      key_event,
    output logic [COUNT_W-1:0]        burst_report,
    // configuration
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DELAY_W-1:0]   cfg_data
);

    // press machine codes
    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_DEBOUNCE = 2'd1;
    localparam logic [1:0] ST_ACTIVE   = 2'd2;
    localparam logic [1:0] ST_REPEAT   = 2'd3;
    // burst machine codes
    localparam logic B_IDLE     = 1'b0;
    localparam logic B_DEBOUNCE = 1'b1;

    // configuration registers
    logic [DELAY_W-1:0] press_delay_reg;
    logic [DELAY_W-1:0] repeat_delay_reg;
    logic [DELAY_W-1:0] debounce_reg;
    logic               released_low_reg;

    // press machine state
    logic [1:0]         press_state_reg, press_state_next;
    logic               stable_level_reg, stable_level_next;
    logic               key_flag_reg, key_flag_next;
    logic [TIME_W-1:0]  debounce_time_reg, debounce_time_next;
    logic [TIME_W-1:0]  active_time_reg, active_time_next;

    // multipress machine state
    logic               burst_state_reg, burst_state_next;
    logic               burst_level_reg, burst_level_next;
    logic [TIME_W-1:0]  burst_db_time_reg, burst_db_time_next;
    logic [TIME_W-1:0]  burst_last_reg, burst_last_next;
    logic [COUNT_W-1:0] burst_count_reg, burst_count_next;
    logic [COUNT_W-1:0] report_c;

    // output register
    logic               out_valid_reg;
    logic               key_event_reg;
    logic [COUNT_W-1:0] multipress_reg;

    logic               in_acc;

    assign in_stall = out_valid_reg & out_stall;
    assign in_acc   = in_valid & ~in_stall;

    assign out_valid    = out_valid_reg;
    assign key_event    = key_event_reg;
    assign burst_report = multipress_reg;

    // press machine: idle -> debounce -> active -> autorepeat
    always_comb
    begin
        press_state_next  = press_state_reg;
        stable_level_next = stable_level_reg;
        key_flag_next     = key_flag_reg;
        debounce_time_next = debounce_time_reg;
        active_time_next  = active_time_reg;
        case (press_state_reg)
            ST_IDLE:
            begin
                if (level != stable_level_reg)
                begin
                    press_state_next   = ST_DEBOUNCE;
                    debounce_time_next = now;
                end
            end
            ST_DEBOUNCE:
            begin
                if (level != stable_level_reg)
                begin
                    // changed level held long enough: accept it
                    if (elapsed(now, debounce_time_reg, debounce_reg))
                    begin
                        press_state_next  = ST_ACTIVE;
                        active_time_next  = now;
                        stable_level_next = level;
                        key_flag_next     = 1'b1;
                    end
                end
                else
                begin
                    press_state_next = ST_IDLE;
                    key_flag_next    = 1'b0;
                end
            end
            ST_ACTIVE, ST_REPEAT:
            begin
                if (level == stable_level_reg)
                begin
                    // first repeat waits the press delay, later ones the interval
                    if (elapsed(now, active_time_reg,
                                (press_state_reg == ST_ACTIVE) ? press_delay_reg
                                                               : repeat_delay_reg))
                    begin
                        press_state_next = ST_REPEAT;
                        active_time_next = now;
                        key_flag_next    = 1'b1;
                    end
                    else
                    begin
                        key_flag_next = 1'b0;
                    end
                end
                else
                begin
                    press_state_next  = ST_IDLE;
                    key_flag_next     = 1'b0;
                    stable_level_next = level;
                end
            end
            default:
            begin
                press_state_next = ST_IDLE;
            end
        endcase
    end

    // multipress machine: count debounced level changes, report after window
    always_comb
    begin
        logic [COUNT_W-1:0] cnt;
        logic [TIME_W-1:0]  last;
        burst_state_next   = burst_state_reg;
        burst_level_next   = burst_level_reg;
        burst_db_time_next = burst_db_time_reg;
        cnt                = burst_count_reg;
        last               = burst_last_reg;
        case (burst_state_reg)
            B_IDLE:
            begin
                if (level != burst_level_reg)
                begin
                    burst_state_next   = B_DEBOUNCE;
                    burst_db_time_next = now;
                end
            end
            default:
            begin
                burst_state_next = B_IDLE;
                if (level != burst_level_reg)
                begin
                    if (elapsed(now, burst_db_time_reg, debounce_reg))
                    begin
                        last             = now;
                        burst_level_next = level;
                        if (cnt != COUNT_MAX)
                            cnt = cnt + 1'b1;
                    end
                    else
                    begin
                        burst_state_next = B_DEBOUNCE;
                    end
                end
            end
        endcase
        burst_last_next = last;
        // report once the press delay has passed since the last change
        if ((cnt != '0) && elapsed(now, last, press_delay_reg))
        begin
            report_c         = cnt;
            burst_count_next = '0;
        end
        else
        begin
            report_c         = '0;
            burst_count_next = cnt;
        end
    end

    // state, configuration and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_delay_reg   <= PRESS_DELAY_RST;
            repeat_delay_reg  <= REPEAT_DELAY_RST;
            debounce_reg      <= DEBOUNCE_RST;
            released_low_reg  <= 1'b0;
            press_state_reg   <= ST_IDLE;
            stable_level_reg  <= 1'b1;
            key_flag_reg      <= 1'b0;
            debounce_time_reg <= '0;
            active_time_reg   <= '0;
            burst_state_reg   <= B_IDLE;
            burst_level_reg   <= 1'b1;
            burst_db_time_reg <= '0;
            burst_last_reg    <= '0;
            burst_count_reg   <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                press_state_reg   <= press_state_next;
                stable_level_reg  <= stable_level_next;
                key_flag_reg      <= key_flag_next;
                debounce_time_reg <= debounce_time_next;
                active_time_reg   <= active_time_next;
                burst_state_reg   <= burst_state_next;
                burst_level_reg   <= burst_level_next;
                burst_db_time_reg <= burst_db_time_next;
                burst_last_reg    <= burst_last_next;
                burst_count_reg   <= burst_count_next;
            end
            // the user must keep config writes to idle (not enforced here); a new idle level reloads both levels
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PRESS_DELAY:  press_delay_reg  <= cfg_data;
                    CFG_REPEAT_DELAY: repeat_delay_reg <= cfg_data;
                    CFG_DEBOUNCE:     debounce_reg     <= cfg_data;
                    CFG_IDLE_LOW:
                    begin
                        released_low_reg <= cfg_data[0];
                        stable_level_reg <= ~cfg_data[0];
                        burst_level_reg  <= ~cfg_data[0];
                    end
                    default: ;
                endcase
            end
            if (in_acc)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            key_event_reg  <= key_flag_next;
            multipress_reg <= report_c;
        end
    end

    // ---- checks ----
    `BDRM_ASSERT(a_out_from_request, clk, rst_n,
        $rose(out_valid_reg) |-> $past(in_acc), "result appeared without a request")
    `BDRM_ASSERT(a_report_clears, clk, rst_n,
        (in_acc && (report_c != '0)) |=> (burst_count_reg == '0),
        "burst count not cleared after report")
    `BDRM_ASSERT(a_idle_keeps_flag, clk, rst_n,
        (in_acc && (press_state_reg == ST_IDLE)) |=> (key_event_reg == $past(key_flag_reg)),
        "idle state changed the key flag")
    `BDRM_ASSERT(a_idle_level_reload, clk, rst_n,
        (cfg_we && (cfg_index == CFG_IDLE_LOW)) |=>
            ((stable_level_reg == !released_low_reg) && (burst_level_reg == !released_low_reg)),
        "stored levels not reloaded with the idle level")
    `BDRM_ASSERT_ALWAYS(a_reset_empty, clk,
        (rst_n || !out_valid_reg),
        "result register not empty during reset")

endmodule

`default_nettype wire

// ===== tb/sv/button_debounce_repeat_multipress_core_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for button_debounce_repeat_multipress_core: polls are
// predicted by an in-bench model of both state machines and checked per field.
// Depends on bdrm_pkg and the core RTL only.

module button_debounce_repeat_multipress_core_test;
    import bdrm_pkg::*;

    typedef enum logic [1:0] {
        PRESS_IDLE,
        PRESS_DEBOUNCE,
        PRESS_ACTIVE,
        PRESS_REPEAT
    } press_state_t;

    typedef enum logic {
        BURST_IDLE,
        BURST_DEBOUNCE
    } burst_state_t;

    typedef struct packed {
        logic               key;
        logic [COUNT_W-1:0] count;
    } poll_result_t;

    localparam int STALL_PCT    = 28;   // idle / stall rate on each side, percent

    // ------------------------------------------------------------------
    // DUT signals; every input but reset has a known value from time zero
    // ------------------------------------------------------------------
    logic                 clk       = 1'b0;
    logic                 rst_n;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic                 level     = 1'b1;
    logic [TIME_W-1:0]    now       = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 key_event;
    logic [COUNT_W-1:0]   burst_report;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_PRESS_DELAY;
    logic [DELAY_W-1:0]   cfg_data  = '0;

    button_debounce_repeat_multipress_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .level        (level),
        .now          (now),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .key_event    (key_event),
        .burst_report (burst_report),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Button model: register copies plus both machines' state
    // ------------------------------------------------------------------
    logic [DELAY_W-1:0] m_press_delay;
    logic [DELAY_W-1:0] m_repeat_delay;
    logic [DELAY_W-1:0] m_debounce;
    logic               m_released_low;

    press_state_t       m_press;
    logic               m_stable;
    logic               m_key;
    logic [TIME_W-1:0]  m_deb_start;
    logic [TIME_W-1:0]  m_active_start;

    burst_state_t       m_burst;
    logic               m_burst_level;
    logic [TIME_W-1:0]  m_burst_start;
    logic [TIME_W-1:0]  m_burst_last;
    logic [COUNT_W-1:0] m_count;

    // results still owed by the DUT, oldest first
    poll_result_t       expected_polls[$];
    poll_result_t       head;

    int unsigned        errors        = 0;
    int unsigned        requests_sent = 0;
    bit                 gaps_on       = 1'b1;   // random idling/stalls enabled
    logic [TIME_W-1:0]  tick          = '0;     // running tick time for stimulus
    int unsigned        step_max      = 1;      // largest tick advance per poll

    // modulo-2^32 distance, strictly greater than the limit
    function automatic bit ticks_past(
        input logic [TIME_W-1:0]  t,
        input logic [TIME_W-1:0]  start,
        input logic [DELAY_W-1:0] lim
    );
        logic [TIME_W-1:0] d;
        d = t - start;
        return d > lim;
    endfunction

    task automatic reset_model();
        m_press_delay  = PRESS_DELAY_RST;
        m_repeat_delay = REPEAT_DELAY_RST;
        m_debounce     = DEBOUNCE_RST;
        m_released_low = 1'b0;
        m_press        = PRESS_IDLE;
        m_stable       = ~m_released_low;
        m_key          = 1'b0;
        m_deb_start    = '0;
        m_active_start = '0;
        m_burst        = BURST_IDLE;
        m_burst_level  = ~m_released_low;
        m_burst_start  = '0;
        m_burst_last   = '0;
        m_count        = '0;
    endtask

    // Advance the model by one accepted poll and queue the expected result.
    task automatic predict_poll(input logic lv, input logic [TIME_W-1:0] t);
        poll_result_t r;
        case (m_press)
            PRESS_IDLE:
            begin
                // key flag holds its value here
                if (lv != m_stable)
                begin
                    m_press     = PRESS_DEBOUNCE;
                    m_deb_start = t;
                end
            end
            PRESS_DEBOUNCE:
            begin
                if (lv != m_stable)
                begin
                    // not yet persisted long enough: key flag holds
                    if (ticks_past(t, m_deb_start, m_debounce))
                    begin
                        m_press        = PRESS_ACTIVE;
                        m_active_start = t;
                        m_stable       = lv;
                        m_key          = 1'b1;
                    end
                end
                else
                begin
                    m_press = PRESS_IDLE;
                    m_key   = 1'b0;
                end
            end
            default:
            begin
                // active waits the press delay, repeat waits the repeat interval
                if (lv == m_stable)
                begin
                    if (ticks_past(t, m_active_start,
                                   (m_press == PRESS_ACTIVE) ? m_press_delay
                                                             : m_repeat_delay))
                    begin
                        m_press        = PRESS_REPEAT;
                        m_active_start = t;
                        m_key          = 1'b1;
                    end
                    else
                    begin
                        m_key = 1'b0;
                    end
                end
                else
                begin
                    m_press  = PRESS_IDLE;
                    m_key    = 1'b0;
                    m_stable = lv;
                end
            end
        endcase

        // burst counter: separately debounced level changes
        if (m_burst == BURST_IDLE)
        begin
            if (lv != m_burst_level)
            begin
                m_burst       = BURST_DEBOUNCE;
                m_burst_start = t;
            end
        end
        else if (lv != m_burst_level)
        begin
            if (ticks_past(t, m_burst_start, m_debounce))
            begin
                m_burst       = BURST_IDLE;
                m_burst_last  = t;
                m_burst_level = lv;
                if (m_count != COUNT_MAX)
                    m_count = m_count + 1'b1;   // saturates at all ones
            end
        end
        else
        begin
            m_burst = BURST_IDLE;
        end

        r.key   = m_key;
        r.count = '0;
        if (m_count != 0 && ticks_past(t, m_burst_last, m_press_delay))
        begin
            r.count = m_count;
            m_count = '0;
        end
        expected_polls.push_back(r);
    endtask

    task automatic flag_mismatch(input string msg);
        errors++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Request driver: payload changes at falling edges, accept at rising
    // ------------------------------------------------------------------
    task automatic send_poll(input logic lv, input logic [TIME_W-1:0] t);
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < STALL_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        level    <= lv;
        now      <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_poll(lv, t);
        requests_sent++;
    endtask

    task automatic poll_step(input logic lv, input int unsigned dt);
        tick = tick + dt;
        send_poll(lv, tick);
    endtask

    // drop valid and hold off until every owed result has come back
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_polls.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DELAY_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_PRESS_DELAY:  m_press_delay  = data;
            CFG_REPEAT_DELAY: m_repeat_delay = data;
            CFG_DEBOUNCE:     m_debounce     = data;
            CFG_IDLE_LOW:
            begin
                // new idle level reloads both stored levels, nothing else
                m_released_low = data[0];
                m_stable       = ~m_released_low;
                m_burst_level  = ~m_released_low;
            end
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(
        input logic [DELAY_W-1:0] press_d,
        input logic [DELAY_W-1:0] repeat_d,
        input logic [DELAY_W-1:0] deb_d,
        input logic               il
    );
        logic [DELAY_W-1:0] il_word;
        il_word    = DELAY_W'($urandom);    // upper bits are don't-care
        il_word[0] = il;
        settle();
        write_reg(CFG_PRESS_DELAY, press_d);
        write_reg(CFG_REPEAT_DELAY, repeat_d);
        write_reg(CFG_DEBOUNCE, deb_d);
        write_reg(CFG_IDLE_LOW, il_word);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall, compare each accepted result in order
    // ------------------------------------------------------------------
    always @(negedge clk)
        out_stall <= gaps_on ? ($urandom_range(99) < STALL_PCT) : 1'b0;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_polls.size() == 0)
            begin
                flag_mismatch("result with no request pending");
            end
            else
            begin
                head = expected_polls.pop_front();
                if (key_event !== head.key)
                    flag_mismatch($sformatf("key_event %b, want %b", key_event, head.key));
                if (burst_report !== head.count)
                    flag_mismatch($sformatf("burst_report %0d, want %0d",
                                            burst_report, head.count));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset delays (press 500, repeat 100, debounce 25), released level high.
    // Walks debounce, press, auto-repeat, release, a bounce, equal-limit
    // boundaries and a tick wrap.
    task automatic test_directed_defaults();
        send_poll(1'b1, 32'h0000_0000);     // idle, tick at zero
        send_poll(1'b0, 32'd1000);          // change seen, debounce starts
        send_poll(1'b0, 32'd1025);          // exactly the debounce time: not yet
        send_poll(1'b0, 32'd1026);          // accepted: key press, burst count 1
        send_poll(1'b0, 32'd1526);          // exactly press delay: no repeat
        send_poll(1'b0, 32'd1527);          // auto-repeat begins, burst reported
        send_poll(1'b0, 32'd1627);          // exactly repeat interval
        send_poll(1'b0, 32'd1628);          // repeat key press
        send_poll(1'b1, 32'd1629);          // release
        send_poll(1'b0, 32'd1630);          // bounce back low
        send_poll(1'b1, 32'd1631);          // debounce abandoned, key cleared
        send_poll(1'b1, 32'd1700);
        send_poll(1'b0, 32'hFFFF_FFF0);     // press just before the wrap
        send_poll(1'b0, 32'h0000_0009);     // 25 ticks across the wrap
        send_poll(1'b0, 32'h0000_000A);     // 26 ticks: accepted
        send_poll(1'b0, 32'h0000_0300);
        send_poll(1'b1, 32'hFFFF_FFFF);     // release at the top tick value
        send_poll(1'b1, 32'h7FFF_FFFF);
        send_poll(1'b1, 32'hFFFF_FFFF);
    endtask

    // All delays zero with released level low, then all delays at maximum.
    task automatic test_delay_extremes();
        logic [TIME_W-1:0] b;
        configure(16'd0, 16'd0, 16'd0, 1'b1);
        b = 32'h0000_1000;
        send_poll(1'b1, b);                 // press, debounce starts
        send_poll(1'b1, b);                 // zero elapsed is not past zero
        send_poll(1'b1, b + 1);             // accepted
        send_poll(1'b1, b + 1);
        send_poll(1'b1, b + 2);             // repeat straight away
        send_poll(1'b1, b + 3);
        send_poll(1'b0, b + 3);
        send_poll(1'b0, b + 3);
        send_poll(1'b0, b + 4);

        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        b = 32'h8000_0000;
        send_poll(1'b0, b);
        send_poll(1'b0, b + 32'd65535);
        send_poll(1'b0, b + 32'd65536);     // accepted after max debounce
        send_poll(1'b0, b + 32'd131071);
        send_poll(1'b0, b + 32'd131072);    // first repeat and burst report
        send_poll(1'b0, b + 32'd196608);
        send_poll(1'b0, b + 32'd196609);
        send_poll(1'b1, b + 32'd196610);
    endtask

    // Over 255 qualified changes inside one window: count must stop at 255.
    task automatic test_count_saturation();
        logic lv;
        configure(16'hFFFF, 16'd0, 16'd0, 1'b0);
        lv   = 1'b1;
        tick = 32'hFFFF_F000;
        repeat (260)
        begin
            lv = ~lv;
            poll_step(lv, 1);
            poll_step(lv, 1);
        end
        poll_step(lv, 70000);               // window closes: report saturated count
        poll_step(lv, 1);
    endtask

    // One phase of button activity: mostly press/hold/release episodes with
    // bounce around the edges, some free noise, part of it at arbitrary tick values.
    task automatic run_phase(input int unsigned target, input logic pressed);
        int unsigned stop_at;
        stop_at = requests_sent + target;
        while (requests_sent < stop_at)
        begin
            if ($urandom_range(99) < 12)
            begin
                if ($urandom_range(3) == 0)
                    tick = $urandom;
                else
                    tick = tick + $urandom_range(step_max);
                send_poll(1'($urandom_range(1)), tick);
            end
            else
            begin
                repeat ($urandom_range(3))
                    poll_step(1'($urandom_range(1)), $urandom_range(step_max));
                repeat ($urandom_range(30, 1))
                    poll_step(pressed, $urandom_range(step_max));
                repeat ($urandom_range(3))
                    poll_step(1'($urandom_range(1)), $urandom_range(step_max));
                repeat ($urandom_range(15, 1))
                    poll_step(~pressed, $urandom_range(step_max));
            end
        end
    endtask

    task automatic test_random_polls();
        logic il;
        for (int ph = 0; ph < 12; ph++)
        begin
            il      = 1'($urandom_range(1));
            gaps_on = (ph != 0);            // first phase runs flat out
            case (ph)
                4:
                begin
                    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, il);
                    step_max = 30000;
                end
                7:
                begin
                    configure(16'd0, 16'd0, 16'd0, il);
                    step_max = 2;
                end
                default:
                begin
                    configure(DELAY_W'($urandom_range(80)), DELAY_W'($urandom_range(30)),
                              DELAY_W'($urandom_range(10)), il);
                    step_max = $urandom_range(8, 1);
                end
            endcase
            tick = (ph == 9) ? 32'hFFFF_FF00 : TIME_W'($urandom);
            // pressed level is the opposite of the released one
            run_phase((ph == 0) ? 200 : 40, il);
        end
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned waited;
        rst_n <= 1'b0;
        reset_model();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_defaults();
        test_delay_extremes();
        test_count_saturation();
        test_random_polls();

        @(negedge clk);
        in_valid <= 1'b0;
        waited = 0;
        while (expected_polls.size() != 0 && waited < 10000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (expected_polls.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", expected_polls.size()));

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog: a stuck handshake ends the run
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/bdrm_pkg.sv
sv/button_debounce_repeat_multipress_core.sv
tb/sv/button_debounce_repeat_multipress_core_test.sv
